// ----- src/mst_pkg.sv -----
// shared constants, types and handshake structs for the multiset slot table
package mst_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned CountOutW = 6;
  localparam int unsigned SlotOutW  = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DELETE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic ins_write;
    logic ins_reject;
    logic ins_next;
    logic del_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic slot_free;
    logic scan_last;
    logic cmp_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- src/mst_ctrl.sv -----
// control state machine: sequences the slot scan for insert and delete
module mst_ctrl
  import mst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  func_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (func_e'(func_i) == FUNC_DELETE) ? ST_DELETE : ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (sts_i.full || sts_i.slot_free || sts_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_DELETE: begin
        if (sts_i.cmp_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_INSERT: begin
        priority if (sts_i.full) begin
          cmd_o.ins_reject = 1'b1;
        end else if (sts_i.slot_free) begin
          cmd_o.ins_write = 1'b1;
        end else if (sts_i.scan_last) begin
          cmd_o.ins_reject = 1'b1;
        end else begin
          cmd_o.ins_next = 1'b1;
        end
      end
      ST_DELETE: begin
        cmd_o.del_step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.res_load = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- src/mst_dp.sv -----
// datapath: value memory, occupied bits, counters and result register
module mst_dp
  import mst_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [ValW-1:0]      value_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [CountOutW-1:0]        removed_count_o,
  output logic [CountOutW-1:0]        occupancy_o,
  output logic                        rejected_o,
  output logic [SlotOutW-1:0]         slot_used_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Capacity - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Capacity);

  logic [ValW-1:0]     mem_q [Capacity];
  logic [ValW-1:0]     rdata_q;
  logic [ValW-1:0]     val_q;
  logic [IdxW-1:0]     idx_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                cmp_vld_q;
  logic [Capacity-1:0] occ_q;
  logic [CntW-1:0]     total_q;
  logic [CntW-1:0]     freed_q;
  logic [IdxW-1:0]     slot_q;
  logic                rej_q;
  logic                out_vld_q;
  logic [CountOutW-1:0] out_removed_q;
  logic [CountOutW-1:0] out_occ_q;
  logic                out_rej_q;
  logic [SlotOutW-1:0] out_slot_q;
  logic                cmp_hit;
  logic                idx_last;

  assign idx_last = (idx_q == LastIdx);
  assign cmp_hit  = cmd_i.del_step && cmp_vld_q && occ_q[cmp_idx_q] && (rdata_q == val_q);

  assign sts_o.full      = (total_q == FullCnt);
  assign sts_o.slot_free = !occ_q[idx_q];
  assign sts_o.scan_last = idx_last;
  assign sts_o.cmp_last  = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign sts_o.out_busy  = out_vld_q && !out_ready_i;

  // single-port value store
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_write) begin
      mem_q[idx_q] <= val_q;
    end else if (cmd_i.del_step) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
    end
    if (cmd_i.del_step) begin
      cmp_idx_q <= idx_q;
    end
    if (cmd_i.res_load) begin
      out_removed_q <= CountOutW'(freed_q);
      out_occ_q     <= CountOutW'(total_q);
      out_rej_q     <= rej_q;
      out_slot_q    <= SlotOutW'(slot_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      occ_q     <= '0;
      total_q   <= '0;
      freed_q   <= '0;
      slot_q    <= '0;
      rej_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        freed_q   <= '0;
        slot_q    <= '0;
        rej_q     <= 1'b0;
      end
      if (cmd_i.ins_next) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.ins_write) begin
        occ_q[idx_q] <= 1'b1;
        total_q      <= total_q + CntW'(1);
        slot_q       <= idx_q;
      end
      if (cmd_i.ins_reject) begin
        rej_q <= 1'b1;
      end
      if (cmd_i.del_step) begin
        // read runs one slot ahead of the compare
        if (!idx_last) begin
          idx_q <= idx_q + IdxW'(1);
        end
        cmp_vld_q <= 1'b1;
      end
      if (cmp_hit) begin
        occ_q[cmp_idx_q] <= 1'b0;
        total_q          <= total_q - CntW'(1);
        freed_q          <= freed_q + CntW'(1);
      end
      if (cmd_i.res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign removed_count_o = out_removed_q;
  assign occupancy_o     = out_occ_q;
  assign rejected_o      = out_rej_q;
  assign slot_used_o     = out_slot_q;

endmodule

// ----- src/multiset_slot_table_core.sv -----
// multiset slot table top level: controller, datapath and checks
// Unordered multiset of signed 32-bit values in Capacity slots (32 here),
// duplicates allowed. An insert (func 0) takes the lowest free slot and
// reports it in slot_used; when the table is full it is dropped with
// rejected set. A delete (func 1) frees every occupied slot holding the
// value and reports the count. Every result carries the occupancy after the
// operation. One item is processed at a time: an insert scans the occupied
// bits from slot 0 and is rejected without a scan when the table is full, a
// delete walks the whole single-port value memory, one read per cycle with
// the compare one slot behind. The result register lets the next transfer
// be accepted while a result waits.
module multiset_slot_table_core
  import mst_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CountOutW-1:0]   removed_count_o,
  output logic [CountOutW-1:0]   occupancy_o,
  output logic                   rejected_o,
  output logic [SlotOutW-1:0]    slot_used_o
);

  cmd_t cmd;
  sts_t sts;

  mst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .removed_count_o (removed_count_o),
    .occupancy_o     (occupancy_o),
    .rejected_o      (rejected_o),
    .slot_used_o     (slot_used_o)
  );

  // a rejected insert never reports a slot or a removal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> removed_count_o == '0 && slot_used_o == '0)
    else $error("rejected result carries slot or count");

  // one item at a time: busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // never write into a full table or an occupied slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_write |-> !sts.full && sts.slot_free)
    else $error("insert into full table or occupied slot");

  // result register is only loaded when it can be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !sts.out_busy)
    else $error("pending result overwritten");

endmodule

// ----- verif/mst_table_checker.sv -----
// checker for the multiset slot table: watches both channels, predicts results and compares
module mst_table_checker
  import mst_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   func_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [CountOutW-1:0]   removed_count_i,
  input  logic [CountOutW-1:0]   occupancy_i,
  input  logic                   rejected_i,
  input  logic [SlotOutW-1:0]    slot_used_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [CountOutW-1:0] removed;
    logic [CountOutW-1:0] occ;
    logic                 rej;
    logic [SlotOutW-1:0]  slot;
  } table_result_t;

  // shadow copy of the table
  logic [ValW-1:0] slot_val [Capacity];
  bit              slot_taken [Capacity];
  int unsigned     held_total = 0;

  table_result_t   expected_q [$];
  int              errors = 0;
  int              depth = 0;

  assign fail_count_o = errors;
  assign pending_o    = depth;

  initial begin
    for (int i = 0; i < Capacity; i++) begin
      slot_val[i]   = '0;
      slot_taken[i] = 1'b0;
    end
  end

  function automatic table_result_t predict_table_op(input func_e op, input logic [ValW-1:0] v);
    table_result_t r;
    int unsigned   freed;
    bit            placed;
    r      = '0;
    freed  = 0;
    placed = 1'b0;
    if (op == FUNC_INSERT) begin
      if (held_total < Capacity) begin
        for (int i = 0; i < Capacity; i++) begin
          if (!placed && !slot_taken[i]) begin
            slot_val[i]   = v;
            slot_taken[i] = 1'b1;
            held_total++;
            r.slot = i[SlotOutW-1:0];
            placed = 1'b1;
          end
        end
      end
      if (!placed) begin
        r.rej  = 1'b1;
        r.slot = '0;
      end
    end else begin
      for (int i = 0; i < Capacity; i++) begin
        if (slot_taken[i] && slot_val[i] == v) begin
          slot_taken[i] = 1'b0;
          freed++;
        end
      end
      held_total = (freed <= held_total) ? held_total - freed : 0;
    end
    r.removed = freed[CountOutW-1:0];
    r.occ     = held_total[CountOutW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      // result side first so a same-edge input transfer never matches itself
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got removed %0d occ %0d rej %0d slot %0d",
                   $time, removed_count_i, occupancy_i, rejected_i, slot_used_i);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("removed_count", 32'(want.removed), 32'(removed_count_i));
          check_field("occupancy", 32'(want.occ), 32'(occupancy_i));
          check_field("rejected", 32'(want.rej), 32'(rejected_i));
          check_field("slot_used", 32'(want.slot), 32'(slot_used_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_table_op(func_e'(func_i), value_i));
      end
      depth = expected_q.size();
    end
  end

endmodule

// ----- verif/tb_multiset_slot_table_core.sv -----
// testbench top for the multiset slot table: stimulus, handshake pacing and verdict
module tb_multiset_slot_table_core;
  import mst_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func_sel = FUNC_INSERT;
  logic signed [ValW-1:0] value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CountOutW-1:0]   removed_count;
  logic [CountOutW-1:0]   occupancy;
  logic                   rejected;
  logic [SlotOutW-1:0]    slot_used;
  int                     fail_count;
  int                     pending;

  bit                     in_calm = 1'b0;
  bit                     out_calm = 1'b0;
  int                     sent = 0;
  logic [ValW-1:0]        live_vals [$];
  logic [ValW-1:0]        pool [8];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  multiset_slot_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func_sel),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .removed_count_o (removed_count),
    .occupancy_o     (occupancy),
    .rejected_o      (rejected),
    .slot_used_o     (slot_used)
  );

  mst_table_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .func_i          (func_sel),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .removed_count_i (removed_count),
    .occupancy_i     (occupancy),
    .rejected_i      (rejected),
    .slot_used_i     (slot_used),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void refresh_pool();
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 7))
        0:       pool[i] = 32'h8000_0000;
        1:       pool[i] = 32'h7fff_ffff;
        2:       pool[i] = '0;
        3:       pool[i] = '1;
        4, 5:    pool[i] = $urandom_range(0, 15);
        default: pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [ValW-1:0] pick_value(input int width);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return pool[$urandom_range(0, width - 1)];
  endfunction

  // one input transfer; valid stays high from the previous item when no gap is drawn
  task automatic send_op(input func_e op, input logic [ValW-1:0] v);
    int gap;
    gap = in_calm ? 0 : draw_wait();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    func_sel = op;
    value    = v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    if (op == FUNC_INSERT) live_vals.push_back(v);
    sent++;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic clear_table();
    logic [ValW-1:0] v;
    while (live_vals.size() > 0) begin
      v = live_vals[0];
      send_op(FUNC_DELETE, v);
      for (int i = live_vals.size() - 1; i >= 0; i--) begin
        if (live_vals[i] == v) live_vals.delete(i);
      end
    end
  endtask

  // result side pacing
  initial begin
    int stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = out_calm ? 0 : draw_wait();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready = 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [ValW-1:0] seed_vals [7];
    logic [ValW-1:0] v;
    int              n;
    seed_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1,
                  32'h5555_5555, 32'haaaa_aaaa};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // write every slot before any delete walks the value memory
    for (int i = 0; i < Capacity; i++) begin
      if (i < 7) v = seed_vals[i];
      else if (i < 12) v = 32'd7;
      else v = $urandom;
      send_op(FUNC_INSERT, v);
    end
    send_op(FUNC_INSERT, 32'd3);            // full table, dropped
    send_op(FUNC_DELETE, 32'd7);            // several copies at once
    send_op(FUNC_INSERT, 32'd9);            // lowest freed slot
    send_op(FUNC_DELETE, 32'h1234_5678);    // likely absent
    send_op(FUNC_DELETE, 32'h8000_0000);
    send_op(FUNC_DELETE, 32'h7fff_ffff);
    send_op(FUNC_DELETE, 32'h0);
    send_op(FUNC_DELETE, 32'hffff_ffff);
    send_op(FUNC_INSERT, 32'h8000_0000);    // refills slot 0
    drain_results();

    while (sent < 1600) begin
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      refresh_pool();
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4: begin
          n = $urandom_range(2, 8);
          repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(0, 9) < 6) send_op(FUNC_INSERT, pick_value(n));
            else send_op(FUNC_DELETE, pick_value(n));
          end
        end
        5, 6: begin
          n = $urandom_range(1, 3);
          repeat ($urandom_range(20, 40)) send_op(FUNC_INSERT, pick_value(n));
          repeat ($urandom_range(1, 4)) send_op(FUNC_DELETE, pick_value(n));
        end
        7: begin
          // whole table holds one value, then a single delete frees all of it
          clear_table();
          v = pick_value(8);
          repeat (Capacity + 1) send_op(FUNC_INSERT, v);
          send_op(FUNC_DELETE, v);
        end
        8: begin
          repeat ($urandom_range(5, 20)) send_op(func_e'($urandom_range(0, 1)), $urandom);
        end
        9: clear_table();
        default: drain_results();
      endcase
    end

    drain_results();
    repeat (4 * Capacity) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
